FILE: src/ubxr_pkg.sv
// ----------------------------------------------------------------------------
// ubxr_pkg
// Shared constants and types for the UBX frame receiver.
// ----------------------------------------------------------------------------
package ubxr_pkg;

   // frame sync pair
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // request opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BODY    = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // register file
   localparam int            CSR_ADDR_W      = 3;
   localparam int            CSR_DATA_W      = 32;
   localparam logic          CSR_TIMEOUT     = 1'b0;
   localparam logic [15:0]   TIMEOUT_RESET   = 16'd1000;

   // decoupling queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified beat as held in the queue
   typedef struct packed {
      logic       is_tick;
      logic       sync_first;
      logic       sync_second;
      logic [7:0] data;
   } entry_type;

   // front -> queue
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // queue -> back
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

FILE: src/ubxr_channels.sv
// ----------------------------------------------------------------------------
// ubxr channels
// Valid/ready channel interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface ubxr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ubxr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [15:0] byte_offset;
   logic [7:0]  msg_class;
   logic [7:0]  msg_ident;
   logic [15:0] body_length;

   modport source (output valid, output kind, output out_byte, output byte_offset,
                   output msg_class, output msg_ident, output body_length,
                   input ready);
   modport sink   (input valid, input kind, input out_byte, input byte_offset,
                   input msg_class, input msg_ident, input body_length,
                   output ready);
endinterface

FILE: src/ubxr_front.sv
// ----------------------------------------------------------------------------
// ubxr_front
// Accepts request beats and tags them (tick, sync byte matches) for the queue.
// ----------------------------------------------------------------------------
module ubxr_front (
   ubxr_req_if.sink         req_ch,
   input  logic             queue_full,
   output ubxr_pkg::push_type push
);
   import ubxr_pkg::*;

   assign req_ch.ready = !queue_full;

   always_comb begin
      push.valid             = req_ch.valid;
      push.entry.is_tick     = (req_ch.opcode == OP_TICK);
      push.entry.sync_first  = (req_ch.rx_byte == SYNC_FIRST);
      push.entry.sync_second = (req_ch.rx_byte == SYNC_SECOND);
      push.entry.data        = req_ch.rx_byte;
   end

endmodule

FILE: src/ubxr_queue.sv
// ----------------------------------------------------------------------------
// ubxr_queue
// Short FIFO between the front and the parser.
// ----------------------------------------------------------------------------
module ubxr_queue (
   input  logic               clock,
   input  logic               reset,
   input  ubxr_pkg::push_type push,
   output logic               full,
   output ubxr_pkg::head_type head,
   input  logic               pop
);
   import ubxr_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                push_fire, pop_fire;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push_fire = push.valid && !full;
   assign pop_fire  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: src/ubxr_back.sv
// ----------------------------------------------------------------------------
// ubxr_back
// Frame parser: sync hunt, header, body, Fletcher check, tick timeout,
// with a registered response slot.
// ----------------------------------------------------------------------------
module ubxr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        timeout_ticks,
   input  ubxr_pkg::head_type head,
   output logic               pop,
   ubxr_rsp_if.source         rsp_ch
);
   import ubxr_pkg::*;

   localparam logic [3:0] PH_HUNT1  = 4'd0;
   localparam logic [3:0] PH_HUNT2  = 4'd1;
   localparam logic [3:0] PH_CLASS  = 4'd2;
   localparam logic [3:0] PH_IDENT  = 4'd3;
   localparam logic [3:0] PH_LEN_LO = 4'd4;
   localparam logic [3:0] PH_LEN_HI = 4'd5;
   localparam logic [3:0] PH_BODY   = 4'd6;
   localparam logic [3:0] PH_CK_A   = 4'd7;
   localparam logic [3:0] PH_CK_B   = 4'd8;

   logic [3:0]  phase_ff,  phase_in;
   logic [7:0]  sum_a_ff,  sum_a_in;
   logic [7:0]  sum_b_ff,  sum_b_in;
   logic [7:0]  class_ff,  class_in;
   logic [7:0]  ident_ff,  ident_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff,  count_in;
   logic [7:0]  check_ff,  check_in;
   logic [15:0] ticks_ff,  ticks_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff,   kind_in;
   logic [7:0]  byte_ff,   byte_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  oclass_ff, oclass_in;
   logic [7:0]  oident_ff, oident_in;
   logic [15:0] olength_ff, olength_in;

   logic        pop_fire;
   logic        emit;
   logic [1:0]  emit_kind;
   logic [7:0]  emit_byte;
   logic [15:0] emit_offset;
   logic [7:0]  sum_a_next, sum_b_next;
   logic [15:0] ticks_next, count_next;
   entry_type   e;

   assign e          = head.entry;
   assign pop_fire   = head.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop        = pop_fire;
   assign sum_a_next = sum_a_ff + e.data;
   assign sum_b_next = sum_b_ff + sum_a_next;
   assign ticks_next = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      class_in    = class_ff;
      ident_in    = ident_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      check_in    = check_ff;
      ticks_in    = ticks_ff;
      emit        = 1'b0;
      emit_kind   = KIND_BODY;
      emit_byte   = '0;
      emit_offset = '0;
      if (pop_fire) begin
         if (e.is_tick) begin
            // ticks only count inside a frame
            if (phase_ff != PH_HUNT1 && phase_ff != PH_HUNT2) begin
               ticks_in = ticks_next;
               if (ticks_next >= timeout_ticks) begin
                  emit      = 1'b1;
                  emit_kind = KIND_TIMEOUT;
                  phase_in  = PH_HUNT1;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT1: begin
                  if (e.sync_first) phase_in = PH_HUNT2;
               end
               PH_HUNT2: begin
                  if (e.sync_second) begin
                     sum_a_in  = '0;
                     sum_b_in  = '0;
                     class_in  = '0;
                     ident_in  = '0;
                     length_in = '0;
                     count_in  = '0;
                     check_in  = '0;
                     ticks_in  = '0;
                     phase_in  = PH_CLASS;
                  end else begin
                     // no recheck as first sync byte
                     phase_in = PH_HUNT1;
                  end
               end
               PH_CLASS: begin
                  class_in = e.data;
                  sum_a_in = sum_a_next;
                  sum_b_in = sum_b_next;
                  phase_in = PH_IDENT;
               end
               PH_IDENT: begin
                  ident_in = e.data;
                  sum_a_in = sum_a_next;
                  sum_b_in = sum_b_next;
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  length_in = {8'd0, e.data};
                  sum_a_in  = sum_a_next;
                  sum_b_in  = sum_b_next;
                  phase_in  = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  length_in = {e.data, length_ff[7:0]};
                  sum_a_in  = sum_a_next;
                  sum_b_in  = sum_b_next;
                  count_in  = '0;
                  phase_in  = ({e.data, length_ff[7:0]} == 16'd0) ? PH_CK_A : PH_BODY;
               end
               PH_BODY: begin
                  sum_a_in    = sum_a_next;
                  sum_b_in    = sum_b_next;
                  emit        = 1'b1;
                  emit_kind   = KIND_BODY;
                  emit_byte   = e.data;
                  emit_offset = count_ff;
                  count_in    = count_next;
                  if (count_next >= length_ff) phase_in = PH_CK_A;
               end
               PH_CK_A: begin
                  check_in = e.data;
                  phase_in = PH_CK_B;
               end
               PH_CK_B: begin
                  emit      = 1'b1;
                  emit_kind = (check_ff == sum_a_ff && e.data == sum_b_ff) ?
                              KIND_GOOD : KIND_BAD;
                  phase_in  = PH_HUNT1;
               end
               default: begin
                  phase_in = PH_HUNT1;
               end
            endcase
         end
      end
   end

   // response slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      offset_in    = offset_ff;
      oclass_in    = oclass_ff;
      oident_in    = oident_ff;
      olength_in   = olength_ff;
      if (pop_fire && emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = emit_kind;
         byte_in      = emit_byte;
         offset_in    = emit_offset;
         oclass_in    = class_ff;
         oident_in    = ident_ff;
         olength_in   = length_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT1;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         class_ff     <= '0;
         ident_ff     <= '0;
         length_ff    <= '0;
         count_ff     <= '0;
         check_ff     <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         class_ff     <= class_in;
         ident_ff     <= ident_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         check_ff     <= check_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      byte_ff    <= byte_in;
      offset_ff  <= offset_in;
      oclass_ff  <= oclass_in;
      oident_ff  <= oident_in;
      olength_ff <= olength_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = kind_ff;
   assign rsp_ch.out_byte    = byte_ff;
   assign rsp_ch.byte_offset = offset_ff;
   assign rsp_ch.msg_class   = oclass_ff;
   assign rsp_ch.msg_ident   = oident_ff;
   assign rsp_ch.body_length = olength_ff;

endmodule

FILE: src/ubx_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// ubx_frame_receiver_core
// UBX frame receiver: sync hunt, header capture, body byte stream,
// 8-bit Fletcher check and tick-driven frame timeout.
// ----------------------------------------------------------------------------
// Each request beat is a received byte or a time tick. Sustained rate is one
// beat per clock while the response side keeps up. A beat is written into a
// four-entry queue on the edge it is accepted; the parser takes it from the
// queue head and registers its response (if any) in the response register.
// The rate is set by the combinational parser step in the back end; the
// queue absorbs response-side stalls, and the request side only stalls once
// four beats are waiting. The response register is reloaded in the same
// cycle it is taken. There is no clearing pass after reset. Register map
// (APB, 32-bit data): offset 0x0 holds timeout_ticks in bits 15:0, reset
// 1000; offset 0x4 reads as zero.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_core (
   input  logic                               clock,
   input  logic                               reset,
   ubxr_req_if.sink                           req_ch,
   ubxr_rsp_if.source                         rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ubxr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ubxr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ubxr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import ubxr_pkg::*;

   logic [15:0] timeout_ff, timeout_in;
   logic        csr_write;
   logic        csr_index;
   push_type    push;
   head_type    head;
   logic        queue_full;
   logic        pop;

   // --- register file ------------------------------------------------------
   // zero-wait APB; word index is the address above the byte lanes
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_write && csr_index == CSR_TIMEOUT) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_index == CSR_TIMEOUT) begin
         prdata = {{(CSR_DATA_W-16){1'b0}}, timeout_ff};
      end
   end

   // --- front end: accept and tag beats ------------------------------------
   ubxr_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   // --- decoupling queue ---------------------------------------------------
   ubxr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // --- back end: frame parser and response register -----------------------
   ubxr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .timeout_ticks (timeout_ff),
      .head          (head),
      .pop           (pop),
      .rsp_ch        (rsp_ch)
   );

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ubx_frame_receiver_core. A cycle-free parser model
// predicts the response beat (if any) of every accepted request beat, and a
// monitor compares response beats in order. A directed table covers sync
// corner cases and the good and bad end codes. Random frames, broken frames,
// noise and tick bursts follow under several timeout settings and idling mixes.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ubxr_pkg::*;

   // parser phases of the prediction model
   typedef enum logic [3:0] {
      SEEK_SYNC1, SEEK_SYNC2, GET_CLASS, GET_IDENT, GET_LEN_LO,
      GET_LEN_HI, GET_BODY, GET_CK_A, GET_CK_B
   } parse_phase_type;

   // one response beat, field order as on the response channel
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [15:0] byte_offset;
      logic [7:0]  msg_class;
      logic [7:0]  msg_ident;
      logic [15:0] body_length;
   } rsp_beat_type;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {ROW_PREDICT, ROW_RESULT, ROW_SILENT} row_check_type;

   typedef struct {
      logic          op;
      logic [7:0]    data;
      row_check_type check;
      rsp_beat_type  want;
   } directed_row_type;

   localparam logic [CSR_ADDR_W-1:0] ADDR_TIMEOUT = CSR_ADDR_W'(4 * CSR_TIMEOUT);
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE   = CSR_ADDR_W'(4);
   localparam int TAIL_CYCLES  = 12;   // queue depth plus pipeline, with margin
   localparam int SETTLE_LIMIT = 20000;
   localparam int GROUP_BEATS  = 33;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;
   logic pready;

   ubxr_req_if req_bus ();
   ubxr_rsp_if rsp_bus ();

   ubx_frame_receiver_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   // prediction state
   parse_phase_type phase;
   logic [7:0]   sum_a, sum_b, cur_class, cur_ident, ck_a_seen;
   logic [15:0]  cur_length, body_count, ticks_seen, tick_limit;

   rsp_beat_type pending_results [$];
   int        error_count = 0;
   int        beats_sent  = 0;
   int        send_gap_pct;
   int        stall_pct;

   // sync corner cases, a two-byte body with extreme values, a zero-length
   // frame with a bad second check byte, ticks while hunting and mid-frame
   directed_row_type directed_rows [24] = '{
      '{OP_TICK, 8'h00, ROW_SILENT,  '0},   // tick while hunting
      '{OP_BYTE, 8'hB5, ROW_SILENT,  '0},
      '{OP_BYTE, 8'hB5, ROW_SILENT,  '0},   // second sync mismatch
      '{OP_BYTE, 8'h62, ROW_SILENT,  '0},   // not rechecked as first sync
      '{OP_BYTE, 8'hB5, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h62, ROW_SILENT,  '0},   // sync found
      '{OP_BYTE, 8'hFF, ROW_SILENT,  '0},   // class
      '{OP_TICK, 8'hFF, ROW_SILENT,  '0},   // tick inside frame, far from limit
      '{OP_BYTE, 8'h00, ROW_SILENT,  '0},   // id
      '{OP_BYTE, 8'h02, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h00, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h00, ROW_PREDICT, '0},   // body offset 0
      '{OP_BYTE, 8'hFF, ROW_PREDICT, '0},   // body offset 1
      '{OP_BYTE, 8'h00, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h01, ROW_RESULT,
        {KIND_GOOD, 8'h00, 16'h0000, 8'hFF, 8'h00, 16'h0002}},
      '{OP_BYTE, 8'hB5, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h62, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h01, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h02, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h00, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h00, ROW_SILENT,  '0},   // zero length: check bytes next
      '{OP_BYTE, 8'h03, ROW_SILENT,  '0},
      '{OP_BYTE, 8'h0B, ROW_RESULT,         // good pair would be 03 0A
        {KIND_BAD, 8'h00, 16'h0000, 8'h01, 8'h02, 16'h0000}},
      '{OP_TICK, 8'h5A, ROW_SILENT,  '0}    // back to hunting, ignored
   };

   task automatic flag_mismatch(input string msg);
      if (error_count < 40)
         $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic void reset_parser();
      tick_limit = TIMEOUT_RESET;
      phase      = SEEK_SYNC1;
      sum_a      = '0;
      sum_b      = '0;
      cur_class  = '0;
      cur_ident  = '0;
      cur_length = '0;
      body_count = '0;
      ck_a_seen  = '0;
      ticks_seen = '0;
   endfunction

   function automatic void fold_sum(input logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
   endfunction

   function automatic rsp_beat_type frame_beat(input logic [1:0] kind,
                                               input logic [7:0] value,
                                               input logic [15:0] offset);
      return {kind, value, offset, cur_class, cur_ident, cur_length};
   endfunction

   // one parser step: a byte or a tick, at most one response beat
   function automatic void parse_step(input logic op, input logic [7:0] b,
                                      output bit fired, output rsp_beat_type beat);
      fired = 1'b0;
      beat  = '0;
      if (op == OP_TICK) begin
         if (phase >= GET_CLASS) begin
            if (ticks_seen != 16'hFFFF)
               ticks_seen = ticks_seen + 16'd1;
            if (ticks_seen >= tick_limit) begin
               fired = 1'b1;
               beat  = frame_beat(KIND_TIMEOUT, 8'h00, 16'h0000);
               phase = SEEK_SYNC1;
            end
         end
         return;
      end
      case (phase)
         SEEK_SYNC1: begin
            if (b == SYNC_FIRST)
               phase = SEEK_SYNC2;
         end
         SEEK_SYNC2: begin
            if (b == SYNC_SECOND) begin
               sum_a      = '0;
               sum_b      = '0;
               cur_class  = '0;
               cur_ident  = '0;
               cur_length = '0;
               body_count = '0;
               ck_a_seen  = '0;
               ticks_seen = '0;
               phase      = GET_CLASS;
            end else begin
               phase = SEEK_SYNC1;
            end
         end
         GET_CLASS: begin
            cur_class = b;
            fold_sum(b);
            phase = GET_IDENT;
         end
         GET_IDENT: begin
            cur_ident = b;
            fold_sum(b);
            phase = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            cur_length = {8'h00, b};
            fold_sum(b);
            phase = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            cur_length[15:8] = b;
            fold_sum(b);
            body_count = '0;
            phase = (cur_length == 16'd0) ? GET_CK_A : GET_BODY;
         end
         GET_BODY: begin
            fold_sum(b);
            fired = 1'b1;
            beat  = frame_beat(KIND_BODY, b, body_count);
            body_count = body_count + 16'd1;
            if (body_count >= cur_length)
               phase = GET_CK_A;
         end
         GET_CK_A: begin
            ck_a_seen = b;
            phase = GET_CK_B;
         end
         GET_CK_B: begin
            fired = 1'b1;
            beat  = frame_beat((ck_a_seen == sum_a && b == sum_b) ? KIND_GOOD : KIND_BAD,
                               8'h00, 16'h0000);
            phase = SEEK_SYNC1;
         end
         default: begin
            phase = SEEK_SYNC1;
         end
      endcase
   endfunction

   // drive one request beat, wait for its handshake, then predict
   task automatic send_item(input logic op, input logic [7:0] data,
                            input row_check_type check = ROW_PREDICT,
                            input rsp_beat_type want = '0);
      bit           fired;
      rsp_beat_type beat;
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.rx_byte <= data;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      beats_sent++;
      parse_step(op, data, fired, beat);
      case (check)
         ROW_PREDICT: if (fired) pending_results.push_back(beat);
         ROW_RESULT:  pending_results.push_back(want);
         default: ;
      endcase
   endtask

   // a byte, now and then preceded by a stray tick
   task automatic send_noisy(input logic [7:0] b);
      if ($urandom_range(11) == 0)
         send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, b);
   endtask

   task automatic send_frame();
      logic [7:0]  head [4];
      logic [7:0]  b, acc_a, acc_b, ck_a, ck_b;
      logic [15:0] len;
      if ($urandom_range(1) == 0)
         repeat ($urandom_range(2, 1)) send_noisy(8'($urandom));
      len = ($urandom_range(14) == 0) ? 16'($urandom_range(48, 7))
                                      : 16'($urandom_range(6));
      head[0] = 8'($urandom);
      head[1] = 8'($urandom);
      head[2] = len[7:0];
      head[3] = len[15:8];
      acc_a = '0;
      acc_b = '0;
      send_noisy(SYNC_FIRST);
      send_noisy(SYNC_SECOND);
      for (int i = 0; i < 4 + int'(len); i++) begin
         b = (i < 4) ? head[i] : 8'($urandom);
         acc_a = acc_a + b;
         acc_b = acc_b + acc_a;
         send_noisy(b);
      end
      ck_a = acc_a;
      ck_b = acc_b;
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(1) == 0)
            ck_a = ck_a ^ (8'd1 << $urandom_range(7));
         else
            ck_b = ck_b ^ (8'd1 << $urandom_range(7));
      end
      send_noisy(ck_a);
      send_noisy(ck_b);
   endtask

   // mostly good frames; the rest truncated frames, noise and tick bursts
   task automatic send_group(input int quota);
      int start;
      int pick;
      start = beats_sent;
      while (beats_sent - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_frame();
         end else if (pick < 80) begin
            send_noisy(SYNC_FIRST);
            send_noisy(SYNC_SECOND);
            repeat ($urandom_range(8, 1)) send_noisy(8'($urandom));
         end else if (pick < 92) begin
            repeat ($urandom_range(6, 1))
               send_item(OP_BYTE, ($urandom_range(3) == 0) ? SYNC_FIRST
                                                           : 8'($urandom));
         end else begin
            repeat ($urandom_range(70, 1)) send_item(OP_TICK, 8'($urandom));
         end
      end
   endtask

   // stop sending, wait for outstanding results, then let the queue drain
   task automatic settle();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [15:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = {16'($urandom), value};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (addr == ADDR_TIMEOUT)
         tick_limit = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // response side: random stalls
   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);

   // response monitor: in-order compare against the oldest expectation
   always @(posedge clock) begin : watch_results
      rsp_beat_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.kind, rsp_bus.out_byte, rsp_bus.byte_offset,
                rsp_bus.msg_class, rsp_bus.msg_ident, rsp_bus.body_length};
         if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result beat %h", got));
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 16'(got.kind), 16'(want.kind));
            check_field("out_byte", 16'(got.out_byte), 16'(want.out_byte));
            check_field("byte_offset", got.byte_offset, want.byte_offset);
            check_field("msg_class", 16'(got.msg_class), 16'(want.msg_class));
            check_field("msg_ident", 16'(got.msg_ident), 16'(want.msg_ident));
            check_field("body_length", got.body_length, want.body_length);
         end
      end
   end

   initial begin : stimulus
      logic [15:0] limit;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.opcode  = OP_BYTE;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      send_gap_pct    = 6;
      stall_pct       = 58;
      reset_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part runs at the reset timeout
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].data,
                   directed_rows[i].check, directed_rows[i].want);

      // three idling mixes, each over four timeout settings
      for (int mix = 0; mix < 3; mix++) begin
         send_gap_pct = (mix == 0) ? 6 : (mix == 1) ? 58 : 0;
         stall_pct    = (mix == 0) ? 58 : (mix == 1) ? 6 : 0;
         for (int grp = 0; grp < 4; grp++) begin
            settle();
            case (grp)
               1:       limit = 16'd1;
               2:       limit = 16'hFFFF;
               default: limit = 16'($urandom_range(64, 4));
            endcase
            csr_write(ADDR_TIMEOUT, limit);
            if (grp == 3)
               csr_write(ADDR_SPARE, 16'($urandom));   // unmapped, no effect
            send_group(GROUP_BEATS);
         end
      end

      settle();
      if (pending_results.size() != 0)
         flag_mismatch($sformatf("%0d expected results never arrived",
                                 pending_results.size()));
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
